// ----- rtl/core/averaged_temperature_sensor_macros.svh -----
// Assertion macros shared by the checker of the averaged temperature sensor.
`ifndef AVERAGED_TEMPERATURE_SENSOR_MACROS_SVH
`define AVERAGED_TEMPERATURE_SENSOR_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ATS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ATS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/ats_pkg.sv -----
// Types and constants shared by the averaged temperature sensor modules.
package ats_pkg;

    localparam int W_CHAN    = 2;
    localparam int W_SAMPLE  = 12;
    localparam int W_TEMP    = 14;
    localparam int W_ARG     = 40;
    localparam int W_ROOT    = 20;
    localparam int W_PROD    = 42;
    localparam int W_QTEMP   = 16;
    localparam int W_DIVISOR = 27;
    localparam int FRAC_BITS = 32;
    localparam int DIV_STEPS  = 8;
    localparam int SQRT_STEPS = 4;

    localparam logic [W_CHAN-1:0] CH_TOP  = 2'd0;
    localparam logic [W_CHAN-1:0] CH_SIDE = 2'd1;
    localparam logic [W_CHAN-1:0] CH_BREW = 2'd2;
    localparam logic [W_CHAN-1:0] CH_NONE = 2'd3;

    localparam logic [W_TEMP-1:0] TEMP_INVALID = 14'd15984;
    localparam logic [W_TEMP-1:0] TEMP_RESET   = 14'd14208;
    localparam logic [W_TEMP-1:0] TEMP_MAX     = 14'd16383;
    localparam logic [W_TEMP-1:0] LOW_LIMIT_RESET  = 14'd160;
    localparam logic [W_TEMP-1:0] HIGH_LIMIT_RESET = 14'd2400;

    localparam logic [63:0] CURVE_A = 64'd22310818;
    localparam logic [63:0] CURVE_B = 64'd1732;
    localparam logic [63:0] SCALE_D = 64'd100000;
    localparam logic [21:0] ROOT_K  = 22'd3125000;
    localparam logic [W_PROD-1:0] Y_OFFSET = 42'd2728331136000;
    localparam logic [W_DIVISOR-1:0] T_DIVISOR = 27'd110848000;

    localparam logic REG_LOW_LIMIT  = 1'b0;
    localparam logic REG_HIGH_LIMIT = 1'b1;

    typedef enum logic {
        DIV_ARG,
        DIV_TEMP
    } t_div_sel;

    typedef struct packed {
        logic     load;
        logic     rd;
        logic     merge;
        logic     mark_bad;
        logic     num;
        logic     div_start;
        t_div_sel div_sel;
        logic     sqrt_start;
        logic     mul;
        logic     offs;
        logic     limit;
        logic     finish;
    } t_cmd;

    typedef struct packed {
        logic drop;
        logic failed;
        logic div_done;
        logic sqrt_done;
        logic y_neg;
        logic out_busy;
    } t_status;

endpackage

// ----- rtl/core/ats_div.sv -----
// Iterative restoring divider, several quotient bits per cycle.
module ats_div #(
    parameter int DW    = 64,
    parameter int VW    = 27,
    parameter int STEPS = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    input  logic [VW-1:0] i_divisor,
    output logic          o_done,
    output logic [DW-1:0] o_quot
);

    localparam int CYC   = DW / STEPS;
    localparam int W_CNT = $clog2(CYC + 1);

    logic [DW-1:0]    r_q;
    logic [VW-1:0]    r_rem;
    logic [VW-1:0]    r_dvs;
    logic [W_CNT-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [DW-1:0] w_q;
    logic [VW-1:0] w_rem;
    logic [VW:0]   w_trial;

    always_comb begin
        w_q     = r_q;
        w_rem   = r_rem;
        w_trial = '0;
        for (int k = 0; k < STEPS; k++) begin
            w_trial = {w_rem, w_q[DW-1]};
            w_q     = {w_q[DW-2:0], 1'b0};
            if (w_trial >= {1'b0, r_dvs}) begin
                w_rem  = VW'(w_trial - {1'b0, r_dvs});
                w_q[0] = 1'b1;
            end else begin
                w_rem = w_trial[VW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= W_CNT'(CYC);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == W_CNT'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_q   <= w_q;
            r_rem <= w_rem;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

// ----- rtl/core/ats_sqrt.sv -----
// Iterative integer square root, several root bits per cycle.
module ats_sqrt (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [ats_pkg::W_ARG-1:0]  i_arg,
    output logic                      o_done,
    output logic [ats_pkg::W_ROOT-1:0] o_root
);
    import ats_pkg::*;

    localparam int RW    = W_ROOT;
    localparam int CYC   = RW / SQRT_STEPS;
    localparam int W_CNT = $clog2(CYC + 1);

    logic [W_ARG-1:0] r_a;
    logic [RW-1:0]    r_root;
    logic [RW+1:0]    r_rem;
    logic [W_CNT-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [W_ARG-1:0] w_a;
    logic [RW-1:0]    w_root;
    logic [RW+1:0]    w_rem;
    logic [RW+3:0]    w_rem2;
    logic [RW+3:0]    w_trial;

    always_comb begin
        w_a     = r_a;
        w_root  = r_root;
        w_rem   = r_rem;
        w_rem2  = '0;
        w_trial = '0;
        for (int k = 0; k < SQRT_STEPS; k++) begin
            w_rem2  = {w_rem, w_a[W_ARG-1:W_ARG-2]};
            w_a     = {w_a[W_ARG-3:0], 2'b00};
            w_trial = (RW + 4)'({w_root, 2'b01});
            if (w_rem2 >= w_trial) begin
                w_rem  = (RW + 2)'(w_rem2 - w_trial);
                w_root = {w_root[RW-2:0], 1'b1};
            end else begin
                w_rem  = (RW + 2)'(w_rem2);
                w_root = {w_root[RW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= W_CNT'(CYC);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == W_CNT'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a    <= i_arg;
            r_root <= '0;
            r_rem  <= '0;
        end else if (r_busy) begin
            r_a    <= w_a;
            r_root <= w_root;
            r_rem  <= w_rem;
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

// ----- rtl/core/ats_ctrl.sv -----
// Controller that sequences one sample through ring update and conversion.
module ats_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_valid,
    input  ats_pkg::t_status i_status,
    output logic             o_ready,
    output ats_pkg::t_cmd    o_cmd
);
    import ats_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ADDR,
        S_MERGE,
        S_NUM,
        S_DIV1,
        S_WAIT1,
        S_ROOT,
        S_WAIT2,
        S_MUL,
        S_OFFS,
        S_DIV2,
        S_WAIT3,
        S_LIMIT,
        S_DONE
    } t_state;

    t_state r_state;
    logic   r_ready;
    t_cmd   w_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ready <= 1'b1;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_s_valid && r_ready) begin
                        r_state <= S_ADDR;
                        r_ready <= 1'b0;
                    end
                end
                S_ADDR: begin
                    if (i_status.drop) begin
                        r_state <= S_IDLE;
                        r_ready <= 1'b1;
                    end else begin
                        r_state <= S_MERGE;
                    end
                end
                S_MERGE: r_state <= i_status.failed ? S_DONE : S_NUM;
                S_NUM:   r_state <= S_DIV1;
                S_DIV1:  r_state <= S_WAIT1;
                S_WAIT1: begin
                    if (i_status.div_done) r_state <= S_ROOT;
                end
                S_ROOT:  r_state <= S_WAIT2;
                S_WAIT2: begin
                    if (i_status.sqrt_done) r_state <= S_MUL;
                end
                S_MUL:   r_state <= S_OFFS;
                S_OFFS:  r_state <= i_status.y_neg ? S_DONE : S_DIV2;
                S_DIV2:  r_state <= S_WAIT3;
                S_WAIT3: begin
                    if (i_status.div_done) r_state <= S_LIMIT;
                end
                S_LIMIT: r_state <= S_DONE;
                S_DONE: begin
                    if (!i_status.out_busy) begin
                        r_state <= S_IDLE;
                        r_ready <= 1'b1;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                    r_ready <= 1'b1;
                end
            endcase
        end
    end

    always_comb begin
        w_cmd      = '0;
        w_cmd.load = i_s_valid & r_ready;
        unique case (r_state)
            S_ADDR:  w_cmd.rd = !i_status.drop;
            S_MERGE: begin
                w_cmd.merge    = 1'b1;
                w_cmd.mark_bad = i_status.failed;
            end
            S_NUM:   w_cmd.num = 1'b1;
            S_DIV1: begin
                w_cmd.div_start = 1'b1;
                w_cmd.div_sel   = DIV_ARG;
            end
            S_ROOT:  w_cmd.sqrt_start = 1'b1;
            S_MUL:   w_cmd.mul = 1'b1;
            S_OFFS: begin
                w_cmd.mark_bad = i_status.y_neg;
                w_cmd.offs     = !i_status.y_neg;
            end
            S_DIV2: begin
                w_cmd.div_start = 1'b1;
                w_cmd.div_sel   = DIV_TEMP;
            end
            S_LIMIT: w_cmd.limit = 1'b1;
            S_DONE:  w_cmd.finish = !i_status.out_busy;
            default: w_cmd.rd = 1'b0;
        endcase
    end

    assign o_ready = r_ready;
    assign o_cmd   = w_cmd;

endmodule

// ----- rtl/core/ats_datapath.sv -----
// Datapath: sample rings, running sums, curve evaluation and result register.
module ats_datapath #(
    parameter int RING_DEPTH = 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  ats_pkg::t_cmd                i_cmd,
    output ats_pkg::t_status             o_status,
    input  logic [ats_pkg::W_CHAN-1:0]   i_ch,
    input  logic [ats_pkg::W_SAMPLE-1:0] i_mv,
    input  logic                         i_failed,
    input  logic [ats_pkg::W_TEMP-1:0]   i_low_limit,
    input  logic [ats_pkg::W_TEMP-1:0]   i_high_limit,
    input  logic                         i_m_ready,
    output logic                         o_m_valid,
    output logic [ats_pkg::W_CHAN-1:0]   o_m_ch,
    output logic [ats_pkg::W_TEMP-1:0]   o_m_temp,
    output logic                         o_m_ok,
    output logic [ats_pkg::W_TEMP-1:0]   o_m_mean,
    output logic [ats_pkg::W_TEMP-1:0]   o_m_max
);
    import ats_pkg::*;

    localparam int W_SLOT    = $clog2(RING_DEPTH);
    localparam int W_SUM     = W_SAMPLE + W_SLOT;
    localparam int W_ADDR    = W_SLOT + 2;
    localparam int MEM_DEPTH = 3 * (2 ** W_SLOT);
    localparam logic [63:0] NUM_BASE_VAL = CURVE_A * 64'(RING_DEPTH);
    localparam int W_NUM = $clog2(NUM_BASE_VAL + 64'd1);
    localparam int DW = ((W_NUM + FRAC_BITS + DIV_STEPS - 1) / DIV_STEPS) * DIV_STEPS;
    localparam logic [W_NUM-1:0] NUM_BASE = W_NUM'(NUM_BASE_VAL);
    localparam logic [63:0] DIVISOR_ARG = SCALE_D * 64'(RING_DEPTH);
    localparam logic [W_SLOT-1:0] SLOT_LAST = W_SLOT'(RING_DEPTH - 1);

    logic [W_CHAN-1:0]   r_ch;
    logic [W_SAMPLE-1:0] r_mv;
    logic                r_failed;

    logic [W_SLOT-1:0] r_slot [0:2];
    logic [W_SUM-1:0]  r_sum  [0:2];
    logic [W_TEMP-1:0] r_temp [0:2];

    logic [W_SAMPLE-1:0]  mem [0:MEM_DEPTH-1];
    logic [MEM_DEPTH-1:0] r_valid;
    logic [W_SAMPLE-1:0]  r_rd_data;
    logic                 r_rd_valid;

    logic [W_NUM-1:0]  r_num;
    logic [W_PROD-1:0] r_prod;
    logic [W_PROD-1:0] r_y;
    logic              r_ok;
    logic [W_TEMP-1:0] r_res;

    logic              r_out_valid;
    logic [W_CHAN-1:0] r_out_ch;
    logic [W_TEMP-1:0] r_out_temp;
    logic              r_out_ok;
    logic [W_TEMP-1:0] r_out_mean;
    logic [W_TEMP-1:0] r_out_max;

    logic [W_CHAN-1:0]   w_ci;
    logic [W_ADDR-1:0]   w_addr;
    logic [W_SAMPLE-1:0] w_old;
    logic [W_SUM-1:0]    w_sum_new;
    logic [W_SLOT-1:0]   w_slot_new;
    logic [W_NUM-1:0]    w_num;
    logic [DW-1:0]       w_dividend;
    logic [W_DIVISOR-1:0] w_divisor;
    logic                w_div_done;
    logic [DW-1:0]       w_quot;
    logic                w_sqrt_done;
    logic [W_ROOT-1:0]   w_root;
    logic [W_QTEMP-1:0]  w_q16;
    logic                w_in_lim;
    logic [W_TEMP-1:0]   w_new;
    logic [W_TEMP-1:0]   w_top;
    logic [W_TEMP-1:0]   w_side;
    logic [W_TEMP:0]     w_pair;

    assign w_ci   = (r_ch == CH_NONE) ? CH_TOP : r_ch;
    assign w_addr = {w_ci, r_slot[w_ci]};
    assign w_old  = r_rd_valid ? r_rd_data : '0;

    assign w_sum_new  = r_sum[w_ci] - W_SUM'(w_old) + W_SUM'(r_mv);
    assign w_slot_new = r_failed ? r_slot[w_ci] :
                        ((r_slot[w_ci] == SLOT_LAST) ? '0 : r_slot[w_ci] + 1'b1);

    assign w_num = NUM_BASE - W_NUM'(r_sum[w_ci]) * W_NUM'(CURVE_B);

    assign w_dividend = (i_cmd.div_sel == DIV_ARG) ? DW'({r_num, {FRAC_BITS{1'b0}}})
                                                   : DW'(r_y);
    assign w_divisor  = (i_cmd.div_sel == DIV_ARG) ? W_DIVISOR'(DIVISOR_ARG) : T_DIVISOR;

    ats_div #(
        .DW    (DW),
        .VW    (W_DIVISOR),
        .STEPS (DIV_STEPS)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    ats_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.sqrt_start),
        .i_arg   (w_quot[W_ARG-1:0]),
        .o_done  (w_sqrt_done),
        .o_root  (w_root)
    );

    assign w_q16    = w_quot[W_QTEMP-1:0];
    assign w_in_lim = (w_q16 <= W_QTEMP'(TEMP_MAX)) &&
                      (W_QTEMP'(i_low_limit) <= w_q16) &&
                      (w_q16 <= W_QTEMP'(i_high_limit));

    assign w_new  = r_ok ? r_res : TEMP_INVALID;
    assign w_top  = (w_ci == CH_TOP)  ? w_new : r_temp[CH_TOP];
    assign w_side = (w_ci == CH_SIDE) ? w_new : r_temp[CH_SIDE];
    assign w_pair = {1'b0, w_top} + {1'b0, w_side};

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_rd_data <= mem[w_addr];
        end
        if (i_cmd.merge) begin
            mem[w_addr] <= r_mv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
            r_out_valid <= 1'b0;
            for (int c = 0; c < 3; c++) begin
                r_slot[c] <= '0;
                r_sum[c]  <= '0;
                r_temp[c] <= TEMP_RESET;
            end
        end else begin
            if (i_cmd.rd) begin
                r_rd_valid <= r_valid[w_addr];
            end
            if (i_cmd.merge) begin
                r_valid[w_addr] <= 1'b1;
                r_sum[w_ci]     <= w_sum_new;
                r_slot[w_ci]    <= w_slot_new;
            end
            if (i_cmd.finish) begin
                r_temp[w_ci] <= w_new;
                r_out_valid  <= 1'b1;
            end else if (i_m_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_ch     <= i_ch;
            r_mv     <= i_mv;
            r_failed <= i_failed;
        end
        if (i_cmd.num) begin
            r_num <= w_num;
        end
        if (i_cmd.mul) begin
            r_prod <= {{(W_PROD - W_ROOT){1'b0}}, w_root} * W_PROD'(ROOT_K);
        end
        if (i_cmd.offs) begin
            r_y <= r_prod - Y_OFFSET;
        end
        if (i_cmd.mark_bad) begin
            r_ok <= 1'b0;
        end else if (i_cmd.limit) begin
            r_ok  <= w_in_lim;
            r_res <= w_q16[W_TEMP-1:0];
        end
        if (i_cmd.finish) begin
            r_out_ch   <= w_ci;
            r_out_temp <= w_new;
            r_out_ok   <= r_ok;
            r_out_mean <= w_pair[W_TEMP:1];
            r_out_max  <= (w_top > w_side) ? w_top : w_side;
        end
    end

    assign o_status.drop      = (r_ch == CH_NONE);
    assign o_status.failed    = r_failed;
    assign o_status.div_done  = w_div_done;
    assign o_status.sqrt_done = w_sqrt_done;
    assign o_status.y_neg     = (r_prod < Y_OFFSET);
    assign o_status.out_busy  = r_out_valid & ~i_m_ready;

    assign o_m_valid = r_out_valid;
    assign o_m_ch    = r_out_ch;
    assign o_m_temp  = r_out_temp;
    assign o_m_ok    = r_out_ok;
    assign o_m_mean  = r_out_mean;
    assign o_m_max   = r_out_max;

endmodule

// ----- rtl/core/averaged_temperature_sensor.sv -----
// Top level of the three-channel averaged temperature sensor.
//
// Channel   Direction  Handshake                  Beat contents
// s_axis    in         tvalid / tready            one millivolt sample for one channel
// m_axis    out        tvalid / tready            new temperature with boiler mean and max
// apb       in         psel, penable, pready      low_limit at 0x0, high_limit at 0x4
//
// A good sample passes from acceptance through ring read, merge, numerator, a first divide,
// the square root unit, multiply, offset, a second divide and the limit check to its result;
// both divides run on the shared eight-bit-per-cycle divider.
// A failed read goes from the merge straight to its result, and a beat for channel three is
// dropped at the ring read without a result.
// Reset clears every ring through per-slot valid bits at once, so no clearing pass runs.
// A result that is not taken holds the controller in its final state; the next sample
// is accepted once that result has moved into the output register.
module averaged_temperature_sensor #(
    parameter int RING_DEPTH = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,  // sample_mv[11:0], zero pad[15:12]
    input  logic [2:0]  s_axis_tuser,  // channel[1:0], read_failed[2]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,  // temperature[13:0], boiler_mean[27:14],
                                       // boiler_max[41:28], zero pad[47:42]
    output logic [2:0]  m_axis_tuser,  // channel_out[1:0], in_range[2]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import ats_pkg::*;

    logic [W_TEMP-1:0] r_low_limit;
    logic [W_TEMP-1:0] r_high_limit;

    t_cmd    w_cmd;
    t_status w_status;

    logic              w_m_valid;
    logic [W_CHAN-1:0] w_m_ch;
    logic [W_TEMP-1:0] w_m_temp;
    logic              w_m_ok;
    logic [W_TEMP-1:0] w_m_mean;
    logic [W_TEMP-1:0] w_m_max;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low_limit  <= LOW_LIMIT_RESET;
            r_high_limit <= HIGH_LIMIT_RESET;
        end else if (psel && penable && pwrite && pready) begin
            unique case (paddr[2])
                REG_LOW_LIMIT:  r_low_limit  <= pwdata[W_TEMP-1:0];
                REG_HIGH_LIMIT: r_high_limit <= pwdata[W_TEMP-1:0];
                default:        r_low_limit  <= r_low_limit;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_LOW_LIMIT:  prdata = 32'(r_low_limit);
            REG_HIGH_LIMIT: prdata = 32'(r_high_limit);
            default:        prdata = '0;
        endcase
    end

    ats_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .i_status  (w_status),
        .o_ready   (s_axis_tready),
        .o_cmd     (w_cmd)
    );

    ats_datapath #(
        .RING_DEPTH (RING_DEPTH)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_status     (w_status),
        .i_ch         (s_axis_tuser[1:0]),
        .i_mv         (s_axis_tdata[W_SAMPLE-1:0]),
        .i_failed     (s_axis_tuser[2]),
        .i_low_limit  (r_low_limit),
        .i_high_limit (r_high_limit),
        .i_m_ready    (m_axis_tready),
        .o_m_valid    (w_m_valid),
        .o_m_ch       (w_m_ch),
        .o_m_temp     (w_m_temp),
        .o_m_ok       (w_m_ok),
        .o_m_mean     (w_m_mean),
        .o_m_max      (w_m_max)
    );

    assign m_axis_tvalid = w_m_valid;
    assign m_axis_tdata  = {6'b0, w_m_max, w_m_mean, w_m_temp};
    assign m_axis_tuser  = {w_m_ok, w_m_ch};

endmodule

// ----- rtl/core/ats_checker.sv -----
// Port-level checker for the averaged temperature sensor, bound to the top level.
`include "averaged_temperature_sensor_macros.svh"

module ats_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [15:0] s_axis_tdata,
    input logic [2:0]  s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [47:0] m_axis_tdata,
    input logic [2:0]  m_axis_tuser,
    input logic        psel,
    input logic        penable,
    input logic        pwrite,
    input logic [2:0]  paddr,
    input logic [31:0] pwdata,
    input logic [31:0] prdata,
    input logic        pready
);
    import ats_pkg::*;

    `ATS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "Result beat changed while stalled")
    `ATS_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready, "Sample accepted while the previous one is in flight")
    `ATS_ASSERT_NOW(a_bad_marked, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tuser[2], m_axis_tdata[13:0] == TEMP_INVALID, "Out-of-range result without the invalid marker")
    `ATS_ASSERT_NOW(a_channel_real, i_clk, i_rst_n, m_axis_tvalid, m_axis_tuser[1:0] != CH_NONE, "Result for a channel that does not exist")
    `ATS_ASSERT_NOW(a_max_over_mean, i_clk, i_rst_n, m_axis_tvalid, m_axis_tdata[41:28] >= m_axis_tdata[27:14], "Boiler maximum below boiler mean")

endmodule

bind averaged_temperature_sensor ats_checker u_checker (.*);
